[rtl/core/pbp_pkg.sv]
// Package for the bit packer: command codes, header layout, state codes and
// the command/status structs between controller and datapath. No dependencies.
package pbp_pkg;

  localparam int DEF_MAX_PAD_BITS = 504;

  localparam logic [7:0] CODE_BIT0   = 8'd0;
  localparam logic [7:0] CODE_BIT1   = 8'd1;
  localparam logic [7:0] CODE_ALIGN  = 8'd2;
  localparam logic [7:0] CODE_FIELD  = 8'd10;
  localparam logic [7:0] CODE_OCT_S  = 8'd20;
  localparam logic [7:0] CODE_OCT_L  = 8'd21;
  localparam logic [7:0] CODE_UOCT_S = 8'd30;
  localparam logic [7:0] CODE_UOCT_L = 8'd31;
  localparam logic [7:0] CODE_BSTR0  = 8'd40;
  localparam logic [7:0] CODE_BSTR1  = 8'd41;
  localparam logic [7:0] CODE_BSTR2  = 8'd42;
  localparam logic [7:0] CODE_BSTR3  = 8'd43;
  localparam logic [7:0] CODE_PSTR0  = 8'd45;
  localparam logic [7:0] CODE_PSTR1  = 8'd46;
  localparam logic [7:0] CODE_PSTR2  = 8'd47;

  localparam logic [2:0] PHASE_CMD  = 3'd0;
  localparam logic [2:0] PHASE_DATA = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_WORK,
    ST_FINAL,
    ST_ERR
  } pbp_state_t;

  typedef struct packed {
    logic [1:0] u;
    logic [1:0] d;
    logic [1:0] l;
  } pbp_layout_t;

  typedef struct packed {
    logic load;
    logic plan;
    logic step;
    logic final_emit;
    logic err_emit;
  } pbp_cmd_t;

  typedef struct packed {
    logic drop;
    logic fault;
    logic busy;
    logic need_slot;
    logic slot_free;
    logic last;
  } pbp_stat_t;

  function automatic pbp_layout_t pbp_layout(input logic [7:0] c);
    pbp_layout_t r;
    r = '0;
    if (c == CODE_UOCT_S || c == CODE_UOCT_L) r.u = 2'd1;
    case (c)
      CODE_FIELD:               r.d = 2'd1;
      CODE_OCT_S, CODE_UOCT_S:  r.l = 2'd1;
      CODE_OCT_L, CODE_UOCT_L:  r.l = 2'd2;
      CODE_BSTR0, CODE_PSTR0: begin
        r.d = 2'd1;
        r.l = 2'd1;
      end
      CODE_BSTR1: begin
        r.d = 2'd1;
        r.l = 2'd2;
      end
      CODE_BSTR2, CODE_PSTR1: begin
        r.d = 2'd2;
        r.l = 2'd1;
      end
      CODE_BSTR3, CODE_PSTR2: begin
        r.d = 2'd2;
        r.l = 2'd2;
      end
      default: r = r;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/pbp_ctrl.sv]
// Controller of the bit packer: sequences decode, bit pushes, final flush and
// error result. Depends on pbp_pkg.
module pbp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  pbp_pkg::pbp_stat_t st,
  output pbp_pkg::pbp_cmd_t  cmd
);
  import pbp_pkg::*;

  pbp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (st.drop)       state_nxt = ST_IDLE;
        else if (st.fault) state_nxt = ST_ERR;
        else               state_nxt = ST_WORK;
      end
      ST_WORK: begin
        if (!st.busy) state_nxt = st.last ? ST_FINAL : ST_IDLE;
      end
      ST_FINAL:  if (st.slot_free) state_nxt = ST_IDLE;
      ST_ERR:    if (st.slot_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_DECIDE: cmd.plan = 1'b1;
      ST_WORK:   cmd.step = st.busy && (!st.need_slot || st.slot_free);
      ST_FINAL:  cmd.final_emit = st.slot_free;
      ST_ERR:    cmd.err_emit = st.slot_free;
      default:   cmd = '0;
    endcase
  end

endmodule

[rtl/core/pbp_dp.sv]
// Datapath of the bit packer: message state, decode of one input byte,
// bit shifter, partial and held octets, output register. Depends on pbp_pkg.
module pbp_dp #(
  parameter int MAX_PAD_BITS = pbp_pkg::DEF_MAX_PAD_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_tdata,
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast,
  output logic              out_tuser,
  input  pbp_pkg::pbp_cmd_t  cmd,
  output pbp_pkg::pbp_stat_t st
);
  import pbp_pkg::*;

  localparam int PW = $clog2(MAX_PAD_BITS + 1);

  logic [7:0]  byte_r;
  logic        last_r;
  logic [5:0]  code_r;
  logic [2:0]  phase_r;
  logic [15:0] tgt_r, fbl_r, tk_r;
  logic [2:0]  tu_r;
  logic [3:0]  bf_r;
  logic [7:0]  part_r, held_r;
  logic        held_v_r, drop_r;
  logic        align_r;
  logic [3:0]  nb_r;
  logic [7:0]  val_r;
  logic [PW-1:0] pad_r;
  logic        ov_r, olast_r, oerr_r;
  logic [7:0]  odata_r;

  logic        f, al;
  logic [3:0]  nb, step;
  logic [7:0]  val;
  logic [15:0] padv;
  logic        do_fin;
  logic [5:0]  code_n;
  logic [2:0]  phase_n, ph_dec, hsum, hidx;
  logic [15:0] tgt_n, fbl_n, tk_n, fin_tgt, rem;
  logic [2:0]  tu_n;
  logic [7:0]  c8;
  pbp_layout_t lay;
  logic [16:0] padsum;
  logic        slot_free;
  logic        emit_push;
  logic [3:0]  bf_dec;
  logic [7:0]  part_set;
  logic        ov_set;

  assign c8        = {2'b00, code_r};
  assign slot_free = !ov_r || out_tready;

  always_comb begin
    f = 1'b0; al = 1'b0; nb = '0; step = '0; val = byte_r; padv = '0; do_fin = 1'b0;
    code_n = code_r; phase_n = phase_r; tgt_n = tgt_r; fbl_n = fbl_r; tk_n = tk_r;
    tu_n = tu_r; fin_tgt = tgt_r; rem = '0; padsum = '0;
    lay = pbp_layout(c8);
    hsum = {1'b0, lay.u} + {1'b0, lay.d} + {1'b0, lay.l};
    hidx = hsum - phase_r;
    ph_dec = phase_r - 3'd1;
    if (phase_r == PHASE_CMD) begin
      if (byte_r inside {CODE_BIT0, CODE_BIT1}) begin
        nb  = 4'd1;
        val = {byte_r[0], 7'b0};
      end else if (byte_r == CODE_ALIGN) begin
        al = 1'b1;
      end else if (byte_r inside {CODE_FIELD, CODE_OCT_S, CODE_OCT_L, CODE_UOCT_S,
                                  CODE_UOCT_L, CODE_BSTR0, CODE_BSTR1, CODE_BSTR2,
                                  CODE_BSTR3, CODE_PSTR0, CODE_PSTR1, CODE_PSTR2}) begin
        lay = pbp_layout(byte_r);
        code_n = byte_r[5:0];
        tgt_n = '0; fbl_n = '0; tk_n = '0; tu_n = '0;
        phase_n = {1'b0, lay.u} + {1'b0, lay.d} + {1'b0, lay.l};
      end else begin
        f = 1'b1;
      end
    end else if (phase_r == PHASE_DATA) begin
      if (c8 == CODE_FIELD) begin
        nb  = (tgt_r > 16'd8) ? 4'd8 : tgt_r[3:0];
        val = byte_r << (4'd8 - nb);
      end else if (c8 inside {CODE_OCT_S, CODE_OCT_L}) begin
        nb = 4'd8;
      end else if (c8 inside {CODE_UOCT_S, CODE_UOCT_L}) begin
        nb = (fbl_r == 16'd1) ? (4'd8 - {1'b0, tu_r}) : 4'd8;
      end else if (c8 inside {CODE_BSTR0, CODE_BSTR1, CODE_BSTR2, CODE_BSTR3}) begin
        if (tk_r < tgt_r) begin
          if (byte_r > 8'd1) f = 1'b1;
          nb   = 4'd1;
          val  = {byte_r[0], 7'b0};
          tk_n = tk_r + 16'd1;
          step = 4'd1;
        end
      end else begin
        if (tk_r < tgt_r) begin
          rem  = tgt_r - tk_r;
          nb   = (rem > 16'd8) ? 4'd8 : rem[3:0];
          tk_n = tk_r + {12'd0, nb};
          step = nb;
        end
      end
      fbl_n = fbl_r - 16'd1;
      if (fbl_n == '0) begin
        phase_n = PHASE_CMD;
        if (c8 >= CODE_BSTR0) do_fin = 1'b1;
      end
    end else begin
      if ({1'b0, hidx} < {2'b0, lay.u}) tu_n = byte_r[2:0];
      else if ({1'b0, hidx} < {2'b0, lay.u} + {2'b0, lay.d}) tgt_n = {tgt_r[7:0], byte_r};
      else fbl_n = {fbl_r[7:0], byte_r};
      phase_n = ph_dec;
      fin_tgt = tgt_n;
      if (ph_dec == PHASE_CMD) begin
        if (c8 == CODE_FIELD) begin
          fbl_n   = 16'd1;
          phase_n = PHASE_DATA;
        end else if (c8 >= CODE_BSTR0) begin
          tk_n = '0;
          if (fbl_n == '0) do_fin = 1'b1;
          else phase_n = PHASE_DATA;
        end else begin
          if (c8 inside {CODE_OCT_S, CODE_OCT_L}) al = 1'b1;
          phase_n = (fbl_n != '0) ? PHASE_DATA : PHASE_CMD;
        end
      end
    end
    if (do_fin) begin
      padv = (fin_tgt > tk_n) ? (fin_tgt - tk_n) : '0;
      padsum = {1'b0, padv} + {13'd0, step};
      if (padv != '0 && padsum > 17'(MAX_PAD_BITS)) f = 1'b1;
      phase_n = PHASE_CMD;
    end
    if (!f && last_r && phase_n != PHASE_CMD) f = 1'b1;
  end

  assign emit_push = held_v_r;
  assign bf_dec    = bf_r - 4'd1;
  assign part_set  = part_r | ({7'd0, val_r[7]} << bf_dec);
  assign ov_set    = cmd.final_emit || cmd.err_emit ||
                     (cmd.step && !align_r && bf_dec != '0 && emit_push);

  assign st.drop      = drop_r;
  assign st.fault     = f;
  assign st.busy      = align_r || (nb_r != '0) || (pad_r != '0);
  assign st.need_slot = !align_r && emit_push;
  assign st.slot_free = slot_free;
  assign st.last      = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r <= '0; phase_r <= PHASE_CMD; tgt_r <= '0; fbl_r <= '0; tk_r <= '0;
      tu_r <= '0; bf_r <= 4'd8; part_r <= '0; held_r <= '0; held_v_r <= 1'b0;
      drop_r <= 1'b0; align_r <= 1'b0; nb_r <= '0; pad_r <= '0; val_r <= '0;
      ov_r <= 1'b0; olast_r <= 1'b0; oerr_r <= 1'b0; odata_r <= '0;
      byte_r <= '0; last_r <= 1'b0;
    end else begin
      if (ov_set) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
      if (cmd.load) begin
        byte_r <= in_tdata;
        last_r <= in_tlast;
      end
      if (cmd.plan) begin
        if (drop_r) begin
          if (last_r) drop_r <= 1'b0;
        end else if (f) begin
          drop_r <= !last_r;
          code_r <= '0; phase_r <= PHASE_CMD; tgt_r <= '0; fbl_r <= '0; tk_r <= '0;
          tu_r <= '0; bf_r <= 4'd8; part_r <= '0; held_r <= '0; held_v_r <= 1'b0;
        end else begin
          code_r <= code_n; phase_r <= phase_n; tgt_r <= tgt_n; fbl_r <= fbl_n;
          tk_r <= tk_n; tu_r <= tu_n;
          align_r <= al; nb_r <= nb; val_r <= val;
          pad_r <= padv[PW-1:0];
        end
      end
      if (cmd.step) begin
        if (align_r) begin
          align_r <= 1'b0;
          if (bf_r != 4'd8) begin
            held_r <= part_r; held_v_r <= 1'b1; part_r <= '0; bf_r <= 4'd8;
          end
        end else begin
          if (nb_r != '0) begin
            nb_r  <= nb_r - 4'd1;
            val_r <= {val_r[6:0], 1'b0};
          end else begin
            pad_r <= pad_r - PW'(1);
          end
          if (bf_dec == '0) begin
            held_r <= (nb_r != '0) ? part_set : part_r;
            held_v_r <= 1'b1; part_r <= '0; bf_r <= 4'd8;
          end else begin
            if (nb_r != '0) part_r <= part_set;
            bf_r <= bf_dec;
            if (emit_push) begin
              held_v_r <= 1'b0;
              odata_r <= held_r; olast_r <= 1'b0; oerr_r <= 1'b0;
            end
          end
        end
      end
      if (cmd.final_emit) begin
        olast_r <= 1'b1; oerr_r <= 1'b0;
        odata_r <= (bf_r != 4'd8) ? part_r : (held_v_r ? held_r : 8'd0);
        code_r <= '0; phase_r <= PHASE_CMD; tgt_r <= '0; fbl_r <= '0; tk_r <= '0;
        tu_r <= '0; bf_r <= 4'd8; part_r <= '0; held_r <= '0; held_v_r <= 1'b0;
      end
      if (cmd.err_emit) begin
        olast_r <= 1'b1; oerr_r <= 1'b1; odata_r <= '0;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = oerr_r;

  a_held_empty: assert property (@(posedge clk) disable iff (!rst_n)
    held_v_r |-> bf_r == 4'd8) else $error("held octet with partial bits");
  a_bf_range: assert property (@(posedge clk) disable iff (!rst_n)
    bf_r >= 4'd1 && bf_r <= 4'd8) else $error("free bit count out of range");
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && oerr_r |-> odata_r == 8'd0 && olast_r) else $error("malformed error result");

endmodule

[rtl/core/per_bit_packer.sv]
// Top level of the bit packer: joins controller and datapath.
// Depends on pbp_pkg, pbp_ctrl and pbp_dp.
//
//   channel | direction | tdata          | tlast    | tuser
//   in_     | slave     | in_byte [7:0]  | in_last  | -
//   out_    | master    | out_byte [7:0] | out_last | error
//
// Each input byte is accepted in ST_IDLE, decoded in ST_DECIDE and worked off in ST_WORK,
// where the bit-serial shifter in the datapath pushes its bits and any padding bits and
// does an align; the final flush and an error result wait in ST_FINAL and ST_ERR for a free
// output slot. A dropped byte goes from decode back to accept. New bytes are taken only in ST_IDLE.
// Reset is synchronous and active low and clears all message state.
// A push that must hand out a held octet waits while the output register is full.
module per_bit_packer #(
  parameter int MAX_PAD_BITS = pbp_pkg::DEF_MAX_PAD_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_byte
  output logic       out_tlast,
  output logic       out_tuser   // error
);
  import pbp_pkg::*;

  pbp_cmd_t  cmd;
  pbp_stat_t st;

  pbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  pbp_dp #(.MAX_PAD_BITS(MAX_PAD_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .st         (st)
  );

endmodule

[test/tb.sv]
// Self-checking testbench for per_bit_packer: a directed table, then random framed messages.
// Results are checked against a bit-level packing predictor or a typed row's result; uses pbp_pkg and per_bit_packer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pbp_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       err;
  } octet_t;

  typedef struct {
    logic [7:0] b;
    logic       l;
    bit         typed;
    octet_t     res;
  } row_t;

  logic       clk = 0;
  logic       rst_n = 0;
  logic       in_tvalid = 0;
  logic       in_tready;
  logic [7:0] in_tdata = 0;
  logic       in_tlast = 0;
  logic       out_tvalid;
  logic       out_tready = 0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  per_bit_packer dut (.*);

  always #5 clk = ~clk;

  octet_t octets_due[$];
  octet_t step_octets[$];
  row_t   rows[$];
  bit     failed = 0;
  int     send_idle = 0;
  int     recv_stall = 0;
  int     items_sent = 0;

  int unsigned cmd, phase, tgt, bytes_left, taken, tunused, free_bits, part, held;
  bit held_v, dropping, flt;

  function automatic void emit(int unsigned b, bit l, bit e);
    octet_t o;
    o.data = b[7:0];
    o.last = l;
    o.err  = e;
    if (step_octets.size() < 64) step_octets.push_back(o);
  endfunction

  function automatic void clear_msg();
    cmd = 0; phase = 0; tgt = 0; bytes_left = 0; taken = 0; tunused = 0;
    free_bits = 8; part = 0; held = 0; held_v = 0;
  endfunction

  function automatic void finish_octet(int unsigned v);
    if (held_v) emit(held, 0, 0);
    held = v & 8'hFF;
    held_v = 1;
  endfunction

  function automatic void push_bit(int unsigned v);
    if (free_bits < 1 || free_bits > 8) free_bits = 8;
    if (v & 1) part |= 1 << (free_bits - 1);
    free_bits--;
    if (free_bits == 0) begin
      finish_octet(part);
      part = 0;
      free_bits = 8;
    end else if (held_v) begin
      emit(held, 0, 0);
      held_v = 0;
    end
  endfunction

  function automatic void push_bits(int unsigned v, int unsigned n);
    for (int unsigned i = n; i > 0; i--) push_bit(v >> (i - 1));
  endfunction

  function automatic void align_out();
    if (free_bits != 8) begin
      finish_octet(part);
      part = 0;
      free_bits = 8;
    end
  endfunction

  function automatic void hdr_shape(int unsigned c, output int unsigned u, d, l);
    u = (c == CODE_UOCT_S || c == CODE_UOCT_L) ? 1 : 0;
    d = 0;
    l = 0;
    case (c)
      CODE_FIELD: d = 1;
      CODE_OCT_S, CODE_UOCT_S: l = 1;
      CODE_OCT_L, CODE_UOCT_L: l = 2;
      CODE_BSTR0, CODE_PSTR0: begin d = 1; l = 1; end
      CODE_BSTR1: begin d = 1; l = 2; end
      CODE_BSTR2, CODE_PSTR1: begin d = 2; l = 1; end
      CODE_BSTR3, CODE_PSTR2: begin d = 2; l = 2; end
      default: d = 0;
    endcase
  endfunction

  function automatic void finish_string(int unsigned step_bits);
    int unsigned pad;
    pad = tgt > taken ? tgt - taken : 0;
    if (pad > 0 && step_bits + pad > DEF_MAX_PAD_BITS) begin
      flt = 1;
      return;
    end
    for (int unsigned i = 0; i < pad; i++) push_bit(0);
    phase = 0;
  endfunction

  function automatic void start_data();
    if (cmd == CODE_FIELD) begin
      bytes_left = 1;
      phase = PHASE_DATA;
      return;
    end
    if (cmd == CODE_OCT_S || cmd == CODE_OCT_L) align_out();
    if (cmd >= CODE_BSTR0) begin
      taken = 0;
      if (bytes_left == 0) begin
        finish_string(0);
        return;
      end
    end
    phase = bytes_left ? PHASE_DATA : 0;
  endfunction

  function automatic void header_byte(int unsigned b);
    int unsigned u, d, l, h, i;
    hdr_shape(cmd, u, d, l);
    h = u + d + l;
    if (phase > h) begin
      phase = 0;
      return;
    end
    i = h - phase;
    if (i < u) tunused = b & 7;
    else if (i < u + d) tgt = ((tgt << 8) | b) & 16'hFFFF;
    else bytes_left = ((bytes_left << 8) | b) & 16'hFFFF;
    phase--;
    if (phase == 0) start_data();
  endfunction

  function automatic void data_byte(int unsigned b);
    int unsigned step, n;
    step = 0;
    if (cmd == CODE_FIELD) begin
      n = tgt > 8 ? 8 : tgt;
      push_bits(b, n);
    end else if (cmd == CODE_OCT_S || cmd == CODE_OCT_L) begin
      push_bits(b, 8);
    end else if (cmd == CODE_UOCT_S || cmd == CODE_UOCT_L) begin
      n = (bytes_left == 1) ? 8 - (tunused & 7) : 8;
      push_bits(b >> (8 - n), n);
    end else if (cmd >= CODE_BSTR0 && cmd <= CODE_BSTR3) begin
      if (taken < tgt) begin
        if (b > 1) begin
          flt = 1;
          return;
        end
        push_bit(b);
        taken++;
        step = 1;
      end
    end else if (taken < tgt) begin
      n = tgt - taken;
      if (n > 8) n = 8;
      push_bits(b >> (8 - n), n);
      taken += n;
      step = n;
    end
    bytes_left = (bytes_left - 1) & 16'hFFFF;
    if (bytes_left == 0) begin
      if (cmd >= CODE_BSTR0) finish_string(step);
      else phase = 0;
    end
  endfunction

  function automatic void command_byte(int unsigned b);
    int unsigned u, d, l;
    case (b)
      CODE_BIT0, CODE_BIT1: push_bit(b);
      CODE_ALIGN: align_out();
      CODE_FIELD, CODE_OCT_S, CODE_OCT_L, CODE_UOCT_S, CODE_UOCT_L,
      CODE_BSTR0, CODE_BSTR1, CODE_BSTR2, CODE_BSTR3,
      CODE_PSTR0, CODE_PSTR1, CODE_PSTR2: begin
        cmd = b; tgt = 0; bytes_left = 0; taken = 0; tunused = 0;
        hdr_shape(b, u, d, l);
        phase = u + d + l;
      end
      default: flt = 1;
    endcase
  endfunction

  // Returns 1 when the byte was dropped as the tail of a bad message.
  function automatic bit pack_byte(int unsigned b, bit last);
    step_octets.delete();
    flt = 0;
    if (dropping) begin
      if (last) dropping = 0;
      return 1;
    end
    if (phase == 0) command_byte(b);
    else if (phase == PHASE_DATA) data_byte(b);
    else header_byte(b);
    if (!flt && last) begin
      if (phase != 0) flt = 1;
      else if (free_bits != 8) emit(part, 1, 0);
      else if (held_v) emit(held, 1, 0);
      else emit(0, 1, 0);
    end
    if (flt) begin
      step_octets.delete();
      clear_msg();
      emit(0, 1, 1);
      dropping = !last;
      return 0;
    end
    if (last) clear_msg();
    return 0;
  endfunction

  task automatic send(logic [7:0] b, logic l, bit typed = 0, octet_t res = '{0, 0, 0});
    int idle;
    idle = 0;
    while ($urandom_range(99) < send_idle && idle < 40) idle++;
    if (idle > 0) begin
      in_tvalid <= 0;
      repeat (idle) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= b;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    if (!pack_byte(b, l)) items_sent++;
    if (typed) octets_due.push_back(res);
    else foreach (step_octets[i]) octets_due.push_back(step_octets[i]);
  endtask

  task automatic send_msg(logic [7:0] m[$]);
    foreach (m[i]) send(m[i], i == m.size() - 1);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (octets_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [7:0] bitbyte();
    return ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(1));
  endfunction

  task automatic add_cmd(ref logic [7:0] m[$]);
    int unsigned k, n, hi;
    k = $urandom_range(13);
    case (k)
      0: m.push_back(CODE_BIT0);
      1: m.push_back(CODE_BIT1);
      2: m.push_back(CODE_ALIGN);
      3: begin
        m.push_back(CODE_FIELD);
        m.push_back(8'($urandom_range(12)));
        m.push_back(8'($urandom));
      end
      4, 5: begin
        n = $urandom_range(4);
        m.push_back(k == 4 ? CODE_OCT_S : CODE_OCT_L);
        if (k == 5) m.push_back(8'd0);
        m.push_back(8'(n));
        repeat (n) m.push_back(8'($urandom));
      end
      6, 7: begin
        n = $urandom_range(4);
        m.push_back(k == 6 ? CODE_UOCT_S : CODE_UOCT_L);
        m.push_back(8'($urandom));
        if (k == 7) m.push_back(8'd0);
        m.push_back(8'(n));
        repeat (n) m.push_back(8'($urandom));
      end
      8, 9, 10, 11: begin
        n = $urandom_range(10);
        hi = $urandom_range(15);
        hi = hi == 0 ? 1 : (hi == 1 ? 2 : 0);
        m.push_back(k == 8 ? CODE_BSTR0 : k == 9 ? CODE_BSTR1 : k == 10 ? CODE_BSTR2 : CODE_BSTR3);
        if (k >= 10) m.push_back(8'(hi));
        m.push_back(8'($urandom_range(12)));
        if (k == 9 || k == 11) m.push_back(8'd0);
        m.push_back(8'(n));
        repeat (n) m.push_back(bitbyte());
      end
      default: begin
        n = $urandom_range(5);
        hi = ($urandom_range(15) == 0) ? 1 : 0;
        m.push_back(k == 12 ? CODE_PSTR0 : (k == 13 && $urandom_range(1)) ? CODE_PSTR1 : CODE_PSTR2);
        if (m[$] != CODE_PSTR0) m.push_back(8'(hi));
        m.push_back(8'($urandom_range(40)));
        if (m[$ - 1] == CODE_PSTR2 || (m.size() > 2 && m[$ - 2] == CODE_PSTR2)) m.push_back(8'd0);
        m.push_back(8'(n));
        repeat (n) m.push_back(8'($urandom));
      end
    endcase
  endtask

  task automatic random_msg();
    logic [7:0] m[$];
    int unsigned kind;
    kind = $urandom_range(19);
    if (kind == 0) begin
      repeat ($urandom_range(1, 4)) m.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 5)) add_cmd(m);
      if (kind == 1 && m.size() > 1) m = m[0:$urandom_range(m.size() - 2)];
      if (kind == 2) m.push_back(CODE_OCT_L);
    end
    send_msg(m);
  endtask

  task automatic row(logic [7:0] b, logic l, bit typed = 0, logic [7:0] eb = 0,
                     logic el = 0, logic ee = 0);
    row_t r;
    r.b = b;
    r.l = l;
    r.typed = typed;
    r.res = '{eb, el, ee};
    rows.push_back(r);
  endtask

  always @(posedge clk) begin
    octet_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (octets_due.size() == 0) begin
        failed = 1;
        $display("%0t: unexpected result data=%h last=%b err=%b", $time,
                 out_tdata, out_tlast, out_tuser);
      end else begin
        e = octets_due.pop_front();
        if (e.data !== out_tdata || e.last !== out_tlast || e.err !== out_tuser) begin
          failed = 1;
          $display("%0t: expected data=%h last=%b err=%b, got data=%h last=%b err=%b",
                   $time, e.data, e.last, e.err, out_tdata, out_tlast, out_tuser);
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int idle_set[4][2];
    idle_set = '{'{0, 0}, '{54, 0}, '{0, 54}, '{30, 30}};
    clear_msg();
    dropping = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    row(CODE_BIT1, 1, 1, 8'h80, 1, 0);
    row(CODE_BIT0, 1, 1, 8'h00, 1, 0);
    row(CODE_ALIGN, 1, 1, 8'h00, 1, 0);
    row(8'hFF, 1, 1, 8'h00, 1, 1);
    row(CODE_FIELD, 1, 1, 8'h00, 1, 1);
    row(CODE_FIELD, 0); row(8'd12, 0); row(8'hFF, 1);
    row(CODE_UOCT_S, 0); row(8'hFF, 0); row(8'd1, 0); row(8'hFF, 1);
    row(CODE_BSTR0, 0); row(8'd3, 0); row(8'd2, 0); row(8'd5, 0); row(8'd1, 1);
    row(CODE_BSTR2, 0); row(8'd2, 0); row(8'd0, 0); row(8'd0, 1, 1, 8'h00, 1, 1);
    row(CODE_BSTR2, 0); row(8'd1, 0); row(8'hF8, 0); row(8'd0, 1);
    row(CODE_PSTR0, 0); row(8'd12, 0); row(8'd2, 0); row(8'hAB, 0); row(8'hCD, 1);
    foreach (rows[i]) send(rows[i].b, rows[i].l, rows[i].typed, rows[i].res);
    drain();

    for (int p = 0; p < 4; p++) begin
      send_idle = idle_set[p][0];
      recv_stall = idle_set[p][1];
      while (items_sent < 30 + 100 * (p + 1)) begin
        random_msg();
        if ($urandom_range(29) == 0) drain();
      end
      drain();
    end

    if (!failed) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
